@@ hdl/aer_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Azimuth-elevation rotation package
// Shared widths, register indexes, mode codes and pipeline control types.
// ----------------------------------------------------------------------------
package aer_pkg;

  // Coordinate format and trig format.
  localparam int unsigned CoordWidth   = 32;
  localparam int unsigned FracBits     = 16;
  localparam int unsigned TrigWidth    = 16;
  localparam int unsigned TrigFrac     = 14;
  localparam int unsigned CoefWidth    = 32;
  localparam int unsigned ScaleWidth   = 32;
  localparam int unsigned ScaleFrac    = 16;
  localparam int unsigned ModeWidth    = 2;

  // Configuration port.
  localparam int unsigned CfgIdxWidth  = 3;
  localparam int unsigned CfgDataWidth = 32;

  // Datapath widths: products, row sums and the scaled value.
  localparam int unsigned ProdWidth    = CoordWidth + CoefWidth;
  localparam int unsigned SumWidth     = ProdWidth;
  localparam int unsigned HiWidth      = SumWidth - ScaleWidth;
  localparam int unsigned HiProdWidth  = HiWidth + ScaleWidth + 1;
  localparam int unsigned LoProdWidth  = 2 * ScaleWidth;
  localparam int unsigned FullWidth    = SumWidth + ScaleWidth + 1;
  localparam int unsigned ProductShift = 2 * TrigFrac + ScaleFrac;
  localparam int unsigned ShiftWidth   = FullWidth - ProductShift;
  localparam int unsigned RoundWidth   = ShiftWidth + 1;

  // Pipeline layout.
  localparam int unsigned NumAxes   = 3;
  localparam int unsigned NumStages = 6;
  localparam int unsigned StIn      = 0;
  localparam int unsigned StProd    = 1;
  localparam int unsigned StSum     = 2;
  localparam int unsigned StPart    = 3;
  localparam int unsigned StComb    = 4;
  localparam int unsigned StOut     = 5;

  typedef logic signed [CoordWidth-1:0] coord_t;
  typedef logic signed [CoefWidth-1:0]  coef_t;
  typedef logic signed [SumWidth-1:0]   sum_t;

  // Register reset values (identity transform, unit scale).
  localparam logic signed [TrigWidth-1:0] TrigOne   = TrigWidth'(1) << TrigFrac;
  localparam logic [ScaleWidth-1:0]       ScaleOne  = ScaleWidth'(1) << ScaleFrac;
  localparam coef_t                       CoefOne   = coef_t'(1) <<< (2 * TrigFrac);

  // Output range limits.
  localparam coord_t MaxCoord = {1'b0, {(CoordWidth-1){1'b1}}};
  localparam coord_t MinCoord = {1'b1, {(CoordWidth-1){1'b0}}};

  // Configuration register indexes.
  typedef enum logic [CfgIdxWidth-1:0] {
    RegCosAz   = 0,
    RegSinAz   = 1,
    RegCosEl   = 2,
    RegSinEl   = 3,
    RegInvCell = 4,
    RegMode    = 5,
    RegRound   = 6
  } aer_reg_e;

  // Rotation modes; the unused code behaves as planar.
  typedef enum logic [ModeWidth-1:0] {
    ModeFwd    = 0,
    ModeInv    = 1,
    ModePlanar = 2
  } aer_mode_e;

  // Per-stage load strobes from the pipeline control.
  typedef struct packed {
    logic ld_in;
    logic ld_prod;
    logic ld_sum;
    logic ld_part;
    logic ld_comb;
    logic ld_out;
  } aer_en_t;

  // Settings used by the scaling lanes and the output stage.
  typedef struct packed {
    logic [ScaleWidth-1:0] inv_cell_size;
    logic                  round_en;
    logic                  planar;
  } aer_ctrl_t;

endpackage
`default_nettype wire

@@ hdl/azimuth_elevation_rotate.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Azimuth-elevation rotation
// Rotates one Q16.16 point per request, scales it by the reciprocal cell
// size, and optionally rounds and saturates the result.
//
//   Channel   Direction  Handshake                  Payload
//   input     in         in_valid_i / in_ready_o    coord_a_i, coord_b_i, coord_c_i
//   output    out        out_valid_o / out_ready_i  out_first_o .. out_third_o,
//                                                   saturated_o
//   config    in         cfg_we_i (no wait)         cfg_idx_i, cfg_wdata_i
//
// One request per cycle is sustained while the output is ready; a result passes
// through the input, product, sum, partial product, combine and output stages.
// Reset clears all stage valid bits and loads the identity transform.
// Each stage loads when empty or when the stage after it moves, so bubbles
// close up under a stalled output and nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module azimuth_elevation_rotate import aer_pkg::*; (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    in_valid_i,
  output logic                   in_ready_o,
  input  wire coord_t            coord_a_i,
  input  wire coord_t            coord_b_i,
  input  wire coord_t            coord_c_i,
  output logic                   out_valid_o,
  input  wire                    out_ready_i,
  output coord_t                 out_first_o,
  output coord_t                 out_second_o,
  output coord_t                 out_third_o,
  output logic                   saturated_o,
  input  wire                    cfg_we_i,
  input  wire [CfgIdxWidth-1:0]  cfg_idx_i,
  input  wire [CfgDataWidth-1:0] cfg_wdata_i
);

  logic [NumStages-1:0] vld_q, vld_d, up_vld, load;
  logic [NumStages:0]   rdy;
  aer_en_t              en;
  aer_ctrl_t            ctrl;
  coef_t                coef [NumAxes][NumAxes];
  coord_t               coord_in [NumAxes];
  sum_t                 row_sum [NumAxes];
  coord_t               lane_val [NumAxes];
  logic [NumAxes-1:0]   lane_sat;

  // Stage control: ready ripples back from the output, valid moves forward.
  always_comb begin
    rdy[NumStages] = out_ready_i;
    for (int k = NumStages - 1; k >= 0; k--) begin
      rdy[k] = !vld_q[k] || rdy[k+1];
    end
    up_vld = {vld_q[NumStages-2:0], in_valid_i};
    load   = rdy[NumStages-1:0] & up_vld;
    for (int k = 0; k < NumStages; k++) begin
      vld_d[k] = rdy[k] ? up_vld[k] : vld_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign en.ld_in   = load[StIn];
  assign en.ld_prod = load[StProd];
  assign en.ld_sum  = load[StSum];
  assign en.ld_part = load[StPart];
  assign en.ld_comb = load[StComb];
  assign en.ld_out  = load[StOut];

  assign in_ready_o  = rdy[0];
  assign out_valid_o = vld_q[StOut];

  // Configuration registers and coefficient matrix.
  aer_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .coef_o      (coef),
    .ctrl_o      (ctrl)
  );

  // Matrix-vector product.
  assign coord_in[0] = coord_a_i;
  assign coord_in[1] = coord_b_i;
  assign coord_in[2] = coord_c_i;

  aer_rot u_rot (
    .clk_i   (clk_i),
    .en_i    (en),
    .coord_i (coord_in),
    .coef_i  (coef),
    .sum_o   (row_sum)
  );

  // One scaling lane per output axis.
  for (genvar j = 0; j < NumAxes; j++) begin : g_lane
    aer_scale u_scale (
      .clk_i  (clk_i),
      .en_i   (en),
      .sum_i  (row_sum[j]),
      .ctrl_i (ctrl),
      .val_o  (lane_val[j]),
      .sat_o  (lane_sat[j])
    );
  end

  // Planar mode hides depth, including its clipping.
  assign out_first_o  = ctrl.planar ? '0 : lane_val[0];
  assign out_second_o = lane_val[1];
  assign out_third_o  = lane_val[2];
  assign saturated_o  = (lane_sat[0] && !ctrl.planar) || lane_sat[1] || lane_sat[2];

`ifndef SYNTHESIS
  // An accepted request always occupies the input stage on the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> vld_q[StIn])
    else $error("accepted request did not enter the input stage");

  // With every stage full and the output held, no request may enter.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (&vld_q) && !out_ready_i |-> !in_ready_o)
    else $error("request accepted into a full, stalled pipeline");

  // A new result can only come from a valid combine stage.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(vld_q[StComb]))
    else $error("output became valid without a result behind it");

  // A clipped result shows at least one reported axis at a range limit.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && saturated_o |->
      out_second_o == MaxCoord || out_second_o == MinCoord ||
      out_third_o == MaxCoord || out_third_o == MinCoord ||
      (!ctrl.planar && (out_first_o == MaxCoord || out_first_o == MinCoord)))
    else $error("saturation flag set with no axis at a limit");
`endif

endmodule
`default_nettype wire

@@ hdl/aer_cfg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Configuration registers and coefficient matrix
// Holds the software-written registers and keeps a registered 3x3 matrix of
// Q.28 coefficients built from the sine and cosine values.
// ----------------------------------------------------------------------------
module aer_cfg import aer_pkg::*; (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    cfg_we_i,
  input  wire [CfgIdxWidth-1:0]  cfg_idx_i,
  input  wire [CfgDataWidth-1:0] cfg_wdata_i,
  output coef_t                  coef_o [NumAxes][NumAxes],
  output aer_ctrl_t              ctrl_o
);

  logic signed [TrigWidth-1:0] cos_az_q, sin_az_q, cos_el_q, sin_el_q;
  logic [ScaleWidth-1:0]       inv_cell_q;
  logic [ModeWidth-1:0]        mode_q;
  logic                        round_q;

  logic signed [2*TrigWidth-1:0] ce_ca, ce_sa, se_ca, se_sa;
  coef_t ca_one, sa_one, ce_one, se_one;
  coef_t coef_d [NumAxes][NumAxes];
  coef_t coef_q [NumAxes][NumAxes];
  logic  inverse;

  // Register writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cos_az_q   <= TrigOne;
      sin_az_q   <= '0;
      cos_el_q   <= TrigOne;
      sin_el_q   <= '0;
      inv_cell_q <= ScaleOne;
      mode_q     <= ModeFwd;
      round_q    <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegCosAz:   cos_az_q   <= cfg_wdata_i[TrigWidth-1:0];
        RegSinAz:   sin_az_q   <= cfg_wdata_i[TrigWidth-1:0];
        RegCosEl:   cos_el_q   <= cfg_wdata_i[TrigWidth-1:0];
        RegSinEl:   sin_el_q   <= cfg_wdata_i[TrigWidth-1:0];
        RegInvCell: inv_cell_q <= cfg_wdata_i[ScaleWidth-1:0];
        RegMode:    mode_q     <= cfg_wdata_i[ModeWidth-1:0];
        RegRound:   round_q    <= cfg_wdata_i[0];
        default: begin
        end
      endcase
    end
  end

  // Coefficients: trig products kept whole, single trig values scaled up.
  always_comb begin
    ce_ca   = cos_el_q * cos_az_q;
    ce_sa   = cos_el_q * sin_az_q;
    se_ca   = sin_el_q * cos_az_q;
    se_sa   = sin_el_q * sin_az_q;
    ca_one  = coef_t'(cos_az_q) <<< TrigFrac;
    sa_one  = coef_t'(sin_az_q) <<< TrigFrac;
    ce_one  = coef_t'(cos_el_q) <<< TrigFrac;
    se_one  = coef_t'(sin_el_q) <<< TrigFrac;
    inverse = (mode_q == ModeInv);

    coef_d[0][0] = coef_t'(ce_ca);
    coef_d[1][1] = ca_one;
    coef_d[2][2] = ce_one;
    if (inverse) begin
      coef_d[0][1] = -sa_one;
      coef_d[0][2] = -coef_t'(se_ca);
      coef_d[1][0] = coef_t'(ce_sa);
      coef_d[1][2] = -coef_t'(se_sa);
      coef_d[2][0] = se_one;
      coef_d[2][1] = '0;
    end else begin
      coef_d[0][1] = coef_t'(ce_sa);
      coef_d[0][2] = se_one;
      coef_d[1][0] = -sa_one;
      coef_d[1][2] = '0;
      coef_d[2][0] = -coef_t'(se_ca);
      coef_d[2][1] = -coef_t'(se_sa);
    end
  end

  // The matrix follows the registers in the next cycle; items reach the
  // multipliers only after their input stage, so a fresh write is seen.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j < NumAxes; j++) begin
        for (int i = 0; i < NumAxes; i++) begin
          coef_q[j][i] <= (i == j) ? CoefOne : '0;
        end
      end
    end else begin
      coef_q <= coef_d;
    end
  end

  assign coef_o = coef_q;

  assign ctrl_o.inv_cell_size = inv_cell_q;
  assign ctrl_o.round_en      = round_q;
  assign ctrl_o.planar        = (mode_q != ModeFwd) && (mode_q != ModeInv);

endmodule
`default_nettype wire

@@ hdl/aer_rot.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Rotation stages
// Input register, nine coordinate-by-coefficient products, and the three
// row sums of the matrix-vector product.
// ----------------------------------------------------------------------------
module aer_rot import aer_pkg::*; (
  input  wire          clk_i,
  input  wire aer_en_t en_i,
  input  wire coord_t  coord_i [NumAxes],
  input  wire coef_t   coef_i [NumAxes][NumAxes],
  output sum_t         sum_o [NumAxes]
);

  coord_t                      in_q   [NumAxes];
  logic signed [ProdWidth-1:0] prod_q [NumAxes][NumAxes];
  sum_t                        sum_q  [NumAxes];

  // Input stage: capture the accepted point.
  always_ff @(posedge clk_i) begin
    if (en_i.ld_in) begin
      in_q <= coord_i;
    end
  end

  // Product stage: one signed multiplier per matrix entry.
  always_ff @(posedge clk_i) begin
    if (en_i.ld_prod) begin
      for (int j = 0; j < NumAxes; j++) begin
        for (int i = 0; i < NumAxes; i++) begin
          prod_q[j][i] <= in_q[i] * coef_i[j][i];
        end
      end
    end
  end

  // Sum stage: each row adds its three products exactly.
  always_ff @(posedge clk_i) begin
    if (en_i.ld_sum) begin
      for (int j = 0; j < NumAxes; j++) begin
        sum_q[j] <= sum_t'(prod_q[j][0]) + sum_t'(prod_q[j][1]) + sum_t'(prod_q[j][2]);
      end
    end
  end

  assign sum_o = sum_q;

endmodule
`default_nettype wire

@@ hdl/aer_scale.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Scaling lane
// Multiplies one row sum by the reciprocal cell size in two partial
// products, drops the extra fraction bits, optionally rounds and saturates.
// ----------------------------------------------------------------------------
module aer_scale import aer_pkg::*; (
  input  wire            clk_i,
  input  wire aer_en_t   en_i,
  input  wire sum_t      sum_i,
  input  wire aer_ctrl_t ctrl_i,
  output coord_t         val_o,
  output logic           sat_o
);

  localparam logic [RoundWidth-1:0] Half     = (RoundWidth'(1) << FracBits) >> 1;
  localparam logic [RoundWidth-1:0] FracMask = (RoundWidth'(1) << FracBits) - 1'b1;

  logic [LoProdWidth-1:0]        lo_q;
  logic signed [HiProdWidth-1:0] hi_q;
  logic signed [FullWidth-1:0]   full;
  logic [ShiftWidth-1:0]         shift_q;
  logic [RoundWidth-1:0]         rnd;
  logic                          fits;
  coord_t                        val_d, val_q;
  logic                          sat_d, sat_q;

  // Partial products: low half unsigned, high half signed.
  always_ff @(posedge clk_i) begin
    if (en_i.ld_part) begin
      lo_q <= sum_i[ScaleWidth-1:0] * ctrl_i.inv_cell_size;
      hi_q <= $signed(sum_i[SumWidth-1:ScaleWidth]) * $signed({1'b0, ctrl_i.inv_cell_size});
    end
  end

  // Combine the halves; the arithmetic shift floors toward minus infinity.
  always_comb begin
    full = (FullWidth'(hi_q) <<< ScaleWidth)
         + $signed({{(FullWidth-LoProdWidth){1'b0}}, lo_q});
  end

  always_ff @(posedge clk_i) begin
    if (en_i.ld_comb) begin
      shift_q <= full[FullWidth-1:ProductShift];
    end
  end

  // Optional round half up to whole units, then clip to the coordinate range.
  always_comb begin
    rnd = {shift_q[ShiftWidth-1], shift_q};
    if (ctrl_i.round_en) begin
      rnd = (rnd + Half) & ~FracMask;
    end
    fits  = (&rnd[RoundWidth-1:CoordWidth-1]) || !(|rnd[RoundWidth-1:CoordWidth-1]);
    sat_d = !fits;
    if (fits) begin
      val_d = rnd[CoordWidth-1:0];
    end else if (rnd[RoundWidth-1]) begin
      val_d = MinCoord;
    end else begin
      val_d = MaxCoord;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.ld_out) begin
      val_q <= val_d;
      sat_q <= sat_d;
    end
  end

  assign val_o = val_q;
  assign sat_o = sat_q;

endmodule
`default_nettype wire

@@ sim/aer_rotate_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Azimuth-elevation rotation checker
// Watches the request, result and register ports of the rotation block. It
// keeps a shadow copy of the registers and predicts each rotated, scaled point
// as its request is accepted. It compares every accepted result with the
// oldest prediction and counts the mismatches.
// ----------------------------------------------------------------------------
module aer_rotate_checker import aer_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  input  logic                    in_ready_i,
  input  coord_t                  coord_a_i,
  input  coord_t                  coord_b_i,
  input  coord_t                  coord_c_i,
  input  logic                    out_valid_i,
  input  logic                    out_ready_i,
  input  coord_t                  out_first_i,
  input  coord_t                  out_second_i,
  input  coord_t                  out_third_i,
  input  logic                    saturated_i,
  input  logic                    cfg_we_i,
  input  logic [CfgIdxWidth-1:0]  cfg_idx_i,
  input  logic [CfgDataWidth-1:0] cfg_wdata_i,
  output int                      fail_count_o,
  output int                      pending_o
);

  localparam longint TrigUnit   = longint'(1) << TrigFrac;

  typedef struct packed {
    coord_t first;
    coord_t second;
    coord_t third;
    logic   sat;
  } point_result_t;

  // Shadow copy of the register file.
  logic signed [TrigWidth-1:0] cos_az_q;
  logic signed [TrigWidth-1:0] sin_az_q;
  logic signed [TrigWidth-1:0] cos_el_q;
  logic signed [TrigWidth-1:0] sin_el_q;
  logic [ScaleWidth-1:0]       inv_cell_q;
  logic [ModeWidth-1:0]        mode_q;
  logic                        round_q;

  point_result_t expected_points [$];
  point_result_t want_point;
  int            mismatches = 0;
  int            results_seen = 0;

  assign fail_count_o = mismatches;

  // Prints one line for the mismatch and counts it.
  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t ns: result %0d: %s mismatch, got %h, expected %h",
             $time, results_seen, what, got, want);
    mismatches++;
  endtask

  // Rotates one point with the current settings, then scales, rounds and
  // clips each axis the way the block is specified to.
  function automatic point_result_t rotate_point(input coord_t a, input coord_t b,
                                                 input coord_t c);
    longint              ca, sa, ce, se;
    longint              coef [3][3];
    longint              pt [3];
    longint              row_sum;
    logic signed [127:0] scaled;
    coord_t              lane [3];
    logic                clip;
    logic                planar;
    point_result_t       res;

    ca = longint'(cos_az_q);
    sa = longint'(sin_az_q);
    ce = longint'(cos_el_q);
    se = longint'(sin_el_q);
    planar = (mode_q != ModeFwd) && (mode_q != ModeInv);
    pt[0] = longint'(a);
    pt[1] = longint'(b);
    pt[2] = longint'(c);

    // The inverse matrix is the transpose of the forward one.
    if (mode_q == ModeInv) begin
      coef[0][0] = ce * ca;       coef[0][1] = -sa * TrigUnit; coef[0][2] = -(se * ca);
      coef[1][0] = ce * sa;       coef[1][1] = ca * TrigUnit;  coef[1][2] = -(se * sa);
      coef[2][0] = se * TrigUnit; coef[2][1] = 0;              coef[2][2] = ce * TrigUnit;
    end else begin
      coef[0][0] = ce * ca;       coef[0][1] = ce * sa;        coef[0][2] = se * TrigUnit;
      coef[1][0] = -sa * TrigUnit; coef[1][1] = ca * TrigUnit; coef[1][2] = 0;
      coef[2][0] = -(se * ca);    coef[2][1] = -(se * sa);     coef[2][2] = ce * TrigUnit;
    end

    clip = 1'b0;
    for (int j = 0; j < 3; j++) begin
      row_sum = pt[0] * coef[j][0] + pt[1] * coef[j][1] + pt[2] * coef[j][2];
      // Exact product with the scale, then a flooring shift back to Q16.16.
      scaled = row_sum * $signed({1'b0, inv_cell_q});
      scaled = scaled >>> ProductShift;
      if (round_q) begin
        scaled = scaled + (128'sd1 <<< (FracBits - 1));
        scaled[FracBits-1:0] = '0;
      end
      if (scaled > MaxCoord) begin
        lane[j] = MaxCoord;
      end else if (scaled < MinCoord) begin
        lane[j] = MinCoord;
      end else begin
        lane[j] = scaled[CoordWidth-1:0];
      end
      // In planar mode the depth is dropped and cannot flag a clip.
      if (j == 0 && planar) begin
        lane[j] = '0;
      end else if (scaled > MaxCoord || scaled < MinCoord) begin
        clip = 1'b1;
      end
    end

    res.first  = lane[0];
    res.second = lane[1];
    res.third  = lane[2];
    res.sat    = clip;
    return res;
  endfunction

  // Result check, request prediction and register shadowing.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cos_az_q   = TrigOne;
      sin_az_q   = '0;
      cos_el_q   = TrigOne;
      sin_el_q   = '0;
      inv_cell_q = ScaleOne;
      mode_q     = ModeFwd;
      round_q    = 1'b0;
      expected_points.delete();
      pending_o <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (expected_points.size() == 0) begin
          report_mismatch("unexpected result", out_first_i, '0);
        end else begin
          want_point = expected_points.pop_front();
          if (out_first_i !== want_point.first)
            report_mismatch("out_first", out_first_i, want_point.first);
          if (out_second_i !== want_point.second)
            report_mismatch("out_second", out_second_i, want_point.second);
          if (out_third_i !== want_point.third)
            report_mismatch("out_third", out_third_i, want_point.third);
          if (saturated_i !== want_point.sat)
            report_mismatch("saturated", 32'(saturated_i), 32'(want_point.sat));
        end
        results_seen++;
      end

      if (in_valid_i && in_ready_i) begin
        expected_points.push_back(rotate_point(coord_a_i, coord_b_i, coord_c_i));
      end

      // Register writes take effect for requests after this edge.
      if (cfg_we_i) begin
        case (cfg_idx_i)
          RegCosAz:   cos_az_q   = cfg_wdata_i[TrigWidth-1:0];
          RegSinAz:   sin_az_q   = cfg_wdata_i[TrigWidth-1:0];
          RegCosEl:   cos_el_q   = cfg_wdata_i[TrigWidth-1:0];
          RegSinEl:   sin_el_q   = cfg_wdata_i[TrigWidth-1:0];
          RegInvCell: inv_cell_q = cfg_wdata_i[ScaleWidth-1:0];
          RegMode:    mode_q     = cfg_wdata_i[ModeWidth-1:0];
          RegRound:   round_q    = cfg_wdata_i[0];
          default:    ;
        endcase
      end

      pending_o <= expected_points.size();
    end
  end

endmodule

@@ sim/azimuth_elevation_rotate_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Azimuth-elevation rotation testbench
// Drives points into the rotation block under a series of register settings:
// first a short directed set of corner cases, then random points. Both the
// request and the result sides stall at random. The checker beside the block
// predicts and compares; this module only makes stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module azimuth_elevation_rotate_tb import aer_pkg::*; ();

  localparam int             ClkPeriod    = 12;
  localparam int             ResetCycles  = 7;
  localparam int             StallLimit   = 3000;
  localparam int             TailCycles   = 20;
  localparam int             NumSegments  = 12;
  localparam int             SegmentItems = 70;
  localparam int             TrigSpan     = 1 << TrigFrac;
  localparam logic [1:0]     ModeSpare    = 2'd3;
  localparam coord_t         CoordOne     = 32'sh0001_0000;
  localparam coord_t         CoordHalf    = 32'sh0000_8000;
  localparam logic [ScaleWidth-1:0] ScaleMax = '1;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  coord_t                  coord_a = '0;
  coord_t                  coord_b = '0;
  coord_t                  coord_c = '0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  coord_t                  out_first;
  coord_t                  out_second;
  coord_t                  out_third;
  logic                    saturated;
  logic                    cfg_we = 1'b0;
  logic [CfgIdxWidth-1:0]  cfg_idx = '0;
  logic [CfgDataWidth-1:0] cfg_wdata = '0;
  int                      fail_count;
  int                      pending;

  // Idling controls: calm is shared by both sides, the stall flags are not.
  logic calm = 1'b0;
  logic stall_in = 1'b1;
  logic stall_out = 1'b1;

  azimuth_elevation_rotate uut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .coord_a_i    (coord_a),
    .coord_b_i    (coord_b),
    .coord_c_i    (coord_c),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .out_first_o  (out_first),
    .out_second_o (out_second),
    .out_third_o  (out_third),
    .saturated_o  (saturated),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_wdata_i  (cfg_wdata)
  );

  aer_rotate_checker checker_i (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .coord_a_i    (coord_a),
    .coord_b_i    (coord_b),
    .coord_c_i    (coord_c),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .out_first_i  (out_first),
    .out_second_i (out_second),
    .out_third_i  (out_third),
    .saturated_i  (saturated),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_wdata_i  (cfg_wdata),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #(ClkPeriod / 2) clk = ~clk;
  end

  // Result side: ready drops in bursts unless calm is set or stall_out is low.
  initial begin : result_side
    @(posedge clk);
    forever begin
      if (!calm && stall_out && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
  end

  // Ends the run when nothing moves on either channel for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < StallLimit) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  // Holds one request until it is accepted, with an optional gap before it.
  task automatic send_point(input coord_t a, input coord_t b, input coord_t c);
    if (!calm && stall_in && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    in_valid <= 1'b1;
    coord_a  <= a;
    coord_b  <= b;
    coord_c  <= c;
    do @(posedge clk); while (!in_ready);
  endtask

  // Stops sending and waits until every predicted result has come back.
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic write_reg(input aer_reg_e idx, input logic [CfgDataWidth-1:0] data);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(posedge clk);
  endtask

  // Writes the whole register file while the block is idle.
  task automatic apply_settings(input logic signed [TrigWidth-1:0] ca,
                                input logic signed [TrigWidth-1:0] sa,
                                input logic signed [TrigWidth-1:0] ce,
                                input logic signed [TrigWidth-1:0] se,
                                input logic [ScaleWidth-1:0] inv,
                                input logic [1:0] mode, input logic rnd);
    drain_results();
    write_reg(RegCosAz, CfgDataWidth'(ca));
    write_reg(RegSinAz, CfgDataWidth'(sa));
    write_reg(RegCosEl, CfgDataWidth'(ce));
    write_reg(RegSinEl, CfgDataWidth'(se));
    write_reg(RegInvCell, CfgDataWidth'(inv));
    write_reg(RegMode, CfgDataWidth'(mode));
    write_reg(RegRound, CfgDataWidth'(rnd));
    cfg_we <= 1'b0;
  endtask

  function automatic logic signed [TrigWidth-1:0] pick_trig();
    case ($urandom_range(0, 10))
      8:       return TrigWidth'(TrigSpan);
      9:       return TrigWidth'(-TrigSpan);
      10:      return '0;
      default: return TrigWidth'(int'($urandom_range(0, 2 * TrigSpan)) - TrigSpan);
    endcase
  endfunction

  function automatic logic [ScaleWidth-1:0] pick_scale();
    case ($urandom_range(0, 3))
      0:       return $urandom;
      1:       return $urandom_range(1, 32'h0004_0000);
      2:       return ScaleOne;
      default: return $urandom_range(32'h0000_4000, 32'h0002_0000);
    endcase
  endfunction

  // Mix of full-range, moderate and boundary coordinates.
  function automatic coord_t pick_coord();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return $urandom;
      4, 5, 6, 7: return int'($urandom_range(0, 1 << 22)) - (1 << 21);
      8: begin
        case ($urandom_range(0, 5))
          0:       return MaxCoord;
          1:       return MinCoord;
          2:       return '0;
          3:       return -1;
          4:       return CoordOne;
          default: return CoordHalf;
        endcase
      end
      default: return coord_t'($urandom) >>> $urandom_range(0, 31);
    endcase
  endfunction

  // Corner cases: identity, a real rotation in every mode, zero scale,
  // rounding at the half, trig values off the unit circle and overflow.
  task automatic run_directed();
    // Identity after reset.
    send_point('0, '0, '0);
    send_point(MaxCoord, MinCoord, CoordHalf);
    send_point(MinCoord, MaxCoord, -1);
    send_point(1, -1, CoordOne);

    // Azimuth 45 degrees, elevation 30 degrees.
    apply_settings(11585, 11585, 14189, 8192, ScaleOne, ModeFwd, 1'b0);
    send_point(CoordOne, 2 * CoordOne, -3 * CoordOne);
    send_point(MaxCoord, MaxCoord, MaxCoord);
    apply_settings(11585, 11585, 14189, 8192, ScaleOne, ModeInv, 1'b0);
    send_point(CoordOne, 2 * CoordOne, -3 * CoordOne);
    send_point(MinCoord, MinCoord, MinCoord);

    // Planar and the spare code: depth is zeroed and must not raise the flag.
    apply_settings(11585, 11585, 14189, 8192, ScaleOne, ModePlanar, 1'b0);
    send_point(MaxCoord, '0, '0);
    send_point(CoordOne, 2 * CoordOne, -3 * CoordOne);
    apply_settings(11585, 11585, 14189, 8192, ScaleOne, ModeSpare, 1'b0);
    send_point(CoordOne, 2 * CoordOne, -3 * CoordOne);
    send_point(MaxCoord, '0, '0);

    // Zero cell scale.
    apply_settings(TrigOne, '0, TrigOne, '0, '0, ModeFwd, 1'b0);
    send_point(MaxCoord, MinCoord, 12345);
    send_point(MinCoord, -1, MaxCoord);

    // Rounding half up, including an overflow caused by the rounding itself.
    apply_settings(TrigOne, '0, TrigOne, '0, ScaleOne, ModeFwd, 1'b1);
    send_point(CoordHalf, -CoordHalf, MaxCoord);
    send_point(CoordOne + CoordHalf - 1, CoordOne + CoordHalf, -CoordOne - CoordHalf - 1);
    send_point(MinCoord, -CoordHalf - 1, 1);

    // Trig values off the unit circle with the extreme scales.
    apply_settings(TrigOne, TrigOne, -TrigOne, -TrigOne, ScaleMax, ModeInv, 1'b0);
    send_point(1, -1, 32'sh7F);
    send_point(MinCoord, MaxCoord, '0);
    apply_settings(-TrigOne, -TrigOne, -TrigOne, -TrigOne, 1, ModeFwd, 1'b1);
    send_point(MaxCoord, MaxCoord, MaxCoord);
    send_point(MinCoord, MinCoord, MinCoord);
  endtask

  // One register setting followed by a run of random points.
  task automatic run_segment(input int seg);
    logic signed [TrigWidth-1:0] trig [4];
    logic [ScaleWidth-1:0]       inv;
    logic [1:0]                  mode;
    logic                        rnd;

    foreach (trig[i]) trig[i] = pick_trig();
    inv  = pick_scale();
    mode = $urandom_range(ModeFwd, ModeSpare);
    rnd  = $urandom_range(0, 1);
    case (seg)
      0: begin
        foreach (trig[i]) trig[i] = TrigOne;
        inv  = ScaleMax;
        mode = ModeInv;
        rnd  = 1'b1;
      end
      1: begin
        foreach (trig[i]) trig[i] = -TrigOne;
        inv  = 1;
        mode = ModePlanar;
        rnd  = 1'b0;
      end
      2: mode = ModeSpare;
      default: ;
    endcase
    calm      = (seg == NumSegments - 1);
    stall_in  = (seg != 3) && ($urandom_range(0, 3) != 0);
    stall_out = (seg != 3) && ($urandom_range(0, 3) != 0);
    apply_settings(trig[0], trig[1], trig[2], trig[3], inv, mode, rnd);
    repeat (SegmentItems) send_point(pick_coord(), pick_coord(), pick_coord());
  endtask

  // Main sequence and verdict.
  initial begin
    repeat (ResetCycles) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    run_directed();
    for (int seg = 0; seg < NumSegments; seg++) run_segment(seg);

    drain_results();
    repeat (TailCycles) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

@@ files.f @@
hdl/aer_pkg.sv
hdl/aer_cfg.sv
hdl/aer_rot.sv
hdl/aer_scale.sv
hdl/azimuth_elevation_rotate.sv
sim/aer_rotate_checker.sv
sim/azimuth_elevation_rotate_tb.sv
